FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the LZSS window decompressor.
// Self-contained; define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every rising edge outside reset.
`define LZWD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a rising edge outside reset.
`define LZWD_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LZWD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZWD_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/core/lzwd_pkg.sv
// Package for the LZSS window decompressor: constants and the parser phase type.
// No dependencies; imported by the top level and the testbench.
package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    // The write pointer starts this many entries below the window end (0xFEE).
    localparam int START_BACK       = 18;
    localparam int LEN_BIAS         = 3;
    localparam int MAX_RUN          = 18;
    localparam int RUN_W            = $clog2(MAX_RUN + 1);
    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_REF  = 2'd2
    } phase_t;

endpackage

FILE: rtl/core/lzwd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read during a write to the same address returns the old contents. No dependencies.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/lzss_window_decompressor.sv
// LZSS decompressor with a 4096-byte history window held in one synchronous RAM.
// A literal appears on the output in the cycle after its request is taken; the first byte
// of a reference copy passes the copy registers, RAM read register and output register
// once its second byte is taken. One flag or literal byte per cycle while the output is free;
// a copy blocks new requests and reads the window once per cycle unless its byte is held.
// Reset (rst_n low, asynchronous) clears control state; the window reads as zeros since a
// fill count masks every entry not written since reset or since the last stream byte.
module lzss_window_decompressor
    import lzwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // Compressed stream in.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // last
    // Decompressed bytes out.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_in_run
);

`include "assert_macros.svh"

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = AW + 1;
    localparam logic [AW-1:0] START_PTR = AW'(WINDOW_DEPTH - START_BACK);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);

    // Parser state.
    phase_t         phase_reg, phase_next;
    logic [7:0]     flag_bits_reg, flag_bits_next;
    logic [3:0]     flags_left_reg, flags_left_next;
    logic [7:0]     held_low_reg, held_low_next;

    // Window write side: pointer and number of entries written since the stream began.
    logic [AW-1:0]  wp_reg, wp_next;
    logic [FW-1:0]  fill_reg, fill_next, fill_wr;

    // Copy engine: reads still to issue, next read address, and the read in flight.
    logic [RUN_W-1:0] cp_left_reg, cp_left_next;
    logic [AW-1:0]    cp_addr_reg, cp_addr_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic             pend_fwd_reg, pend_fwd_next;
    logic             pend_ok_reg, pend_ok_next;
    logic [7:0]       pend_fwd_data_reg, pend_fwd_data_next;

    // Output register.
    logic           out_valid_reg, out_valid_next;
    logic           out_last_reg, out_last_next;
    logic [7:0]     out_data_reg, out_data_next;

    logic           out_free;
    logic           s_acc;
    logic           issue;
    logic           emit_cp;
    logic           lit_take;
    logic           ref_start;
    logic           wr_en;
    logic [7:0]     wr_data;
    logic [7:0]     cp_byte;
    logic [7:0]     ram_rd_data;
    logic [AW-1:0]  rd_dist;
    logic [3:0]     flags_after;

    // A new request is taken only when no copy is running and the output slot frees up.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (cp_left_reg == '0) && !pend_reg && out_free;
    assign s_acc    = s_tvalid && s_tready;

    // A read is issued unless the previous read's byte is stuck behind a full output.
    assign issue   = (cp_left_reg != '0) && (!pend_reg || out_free);
    assign emit_cp = pend_reg && out_free;

    // An entry that was never written since the stream began reads as zero; a byte written
    // in the same cycle as its read comes from the forwarding register.
    always_comb
    begin
        if (!pend_ok_reg)
        begin
            cp_byte = 8'h00;
        end
        else if (pend_fwd_reg)
        begin
            cp_byte = pend_fwd_data_reg;
        end
        else
        begin
            cp_byte = ram_rd_data;
        end
    end

    assign flags_after = flags_left_reg - 4'd1;

    // Parser next state.
    always_comb
    begin
        phase_next = phase_reg;
        if (s_acc)
        begin
            if (s_tlast)
            begin
                phase_next = PH_FLAG;
            end
            else
            begin
                case (phase_reg)
                    PH_ITEM:
                    begin
                        if (flag_bits_reg[0])
                        begin
                            phase_next = (flags_after != '0) ? PH_ITEM : PH_FLAG;
                        end
                        else
                        begin
                            phase_next = PH_REF;
                        end
                    end
                    PH_REF:
                    begin
                        phase_next = (flags_left_reg != '0) ? PH_ITEM : PH_FLAG;
                    end
                    default:
                    begin
                        phase_next = PH_ITEM;
                    end
                endcase
            end
        end
    end

    // Parser outputs: flag bookkeeping, literal take and reference start.
    always_comb
    begin
        lit_take        = 1'b0;
        ref_start       = 1'b0;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        held_low_next   = held_low_reg;
        if (s_acc)
        begin
            case (phase_reg)
                PH_ITEM:
                begin
                    flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                    flags_left_next = flags_after;
                    lit_take        = flag_bits_reg[0];
                    if (!flag_bits_reg[0])
                    begin
                        held_low_next = s_tdata;
                    end
                end
                PH_REF:
                begin
                    // A reference whose second byte ends the stream copies nothing.
                    ref_start = !s_tlast;
                end
                default:
                begin
                    flag_bits_next  = s_tdata;
                    flags_left_next = FLAGS_PER_BYTE;
                end
            endcase
            if (s_tlast)
            begin
                flag_bits_next  = '0;
                flags_left_next = '0;
                held_low_next   = '0;
            end
        end
    end

    // Window writes: literals and copied bytes never share a cycle.
    assign wr_en   = lit_take || emit_cp;
    assign wr_data = lit_take ? s_tdata : cp_byte;
    assign fill_wr = (wr_en && (fill_reg != FILL_FULL)) ? fill_reg + FW'(1) : fill_reg;
    assign rd_dist = cp_addr_reg - START_PTR;

    always_comb
    begin
        wp_next   = wr_en ? wp_reg + AW'(1) : wp_reg;
        fill_next = fill_wr;
        if (s_acc && s_tlast)
        begin
            wp_next   = START_PTR;
            fill_next = '0;
        end
    end

    // Copy engine.
    always_comb
    begin
        cp_left_next       = cp_left_reg;
        cp_addr_next       = cp_addr_reg;
        pend_next          = pend_reg;
        pend_last_next     = pend_last_reg;
        pend_fwd_next      = pend_fwd_reg;
        pend_ok_next       = pend_ok_reg;
        pend_fwd_data_next = pend_fwd_data_reg;
        if (ref_start)
        begin
            cp_left_next = RUN_W'(s_tdata[3:0]) + RUN_W'(LEN_BIAS);
            cp_addr_next = AW'({s_tdata[7:4], held_low_reg});
        end
        else if (issue)
        begin
            cp_left_next = cp_left_reg - RUN_W'(1);
            cp_addr_next = cp_addr_reg + AW'(1);
        end
        if (issue)
        begin
            pend_next          = 1'b1;
            pend_last_next     = (cp_left_reg == RUN_W'(1));
            // The RAM returns old data when the read hits the entry being written now.
            pend_fwd_next      = emit_cp && (cp_addr_reg == wp_reg);
            pend_fwd_data_next = cp_byte;
            pend_ok_next       = fill_wr > {1'b0, rd_dist};
        end
        else if (emit_cp)
        begin
            pend_next = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = wr_en;
            out_last_next  = lit_take ? 1'b1 : pend_last_reg;
            out_data_next  = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            wp_reg         <= START_PTR;
            fill_reg       <= '0;
            cp_left_reg    <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_fwd_reg   <= 1'b0;
            pend_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            cp_left_reg    <= cp_left_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            pend_fwd_reg   <= pend_fwd_next;
            pend_ok_reg    <= pend_ok_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_low_reg      <= held_low_next;
        cp_addr_reg       <= cp_addr_next;
        pend_fwd_data_reg <= pend_fwd_data_next;
        out_data_reg      <= out_data_next;
    end

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (cp_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `LZWD_ASSERT(a_run_bound, clk, rst_n, cp_left_reg <= RUN_W'(MAX_RUN), "copy length out of range")
    `LZWD_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_FULL, "fill count past window depth")
    `LZWD_ASSERT(a_last_copy, clk, rst_n, (emit_cp && pend_last_reg) |-> (cp_left_reg == '0), "last copy byte with reads left")
    `LZWD_ASSERT(a_fwd_valid, clk, rst_n, pend_fwd_reg |-> pend_ok_reg, "forwarded byte marked unwritten")
    `LZWD_ASSERT(a_stream_end, clk, rst_n, (s_acc && s_tlast) |=> ((wp_reg == START_PTR) && (fill_reg == '0)), "window not restarted after stream end")

endmodule

FILE: tb/lzss_window_decompressor_tb.sv
// Self-checking testbench for the LZSS window decompressor: directed streams, then random ones.
// Depends on lzwd_pkg and lzss_window_decompressor; a built-in expander predicts every byte.
module lzss_window_decompressor_tb;
    import lzwd_pkg::*;

    localparam int RANDOM_REQUESTS = 500;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
    } expanded_byte_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Expander state, kept in step with every request the block accepts.
    logic [7:0]  hist_window [0:WINDOW_DEPTH_DEF-1];
    logic [11:0] hist_wp;
    logic [7:0]  pending_flags;
    logic [3:0]  flags_unused;
    phase_t      parse_phase;
    logic [7:0]  ref_offset_low;

    expanded_byte_t expected_bytes[$];

    int  error_count;
    int  requests_sent;
    int  stream_budget;
    int  quiet_cycles;
    int  stall_left;
    bit  gap_on;
    bit  stall_on;

    lzss_window_decompressor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_expander();
        for (int i = 0; i < WINDOW_DEPTH_DEF; i++)
            hist_window[i] = 8'h00;
        hist_wp        = 12'(WINDOW_DEPTH_DEF - START_BACK);
        pending_flags  = 8'h00;
        flags_unused   = 4'd0;
        parse_phase    = PH_FLAG;
        ref_offset_low = 8'h00;
    endfunction

    function automatic void emit_byte(input logic [7:0] value, input logic final_one);
        expected_bytes.push_back('{out_byte: value, last_in_run: final_one});
        hist_window[hist_wp] = value;
        hist_wp = hist_wp + 12'd1;
    endfunction

    // Works out the bytes one accepted request produces and advances the parser.
    function automatic void expand_request(input logic [7:0] data, input logic fin);
        logic        flag_bit;
        logic [11:0] copy_from;
        int          run_len;
        case (parse_phase)
            PH_ITEM:
            begin
                flag_bit      = pending_flags[0];
                pending_flags = pending_flags >> 1;
                flags_unused  = flags_unused - 4'd1;
                if (flag_bit)
                begin
                    emit_byte(data, 1'b1);
                    parse_phase = (flags_unused != 4'd0) ? PH_ITEM : PH_FLAG;
                end
                else
                begin
                    ref_offset_low = data;
                    parse_phase    = PH_REF;
                end
            end
            PH_REF:
            begin
                // A reference cut short by the end of the stream copies nothing.
                if (!fin)
                begin
                    copy_from = {data[7:4], ref_offset_low};
                    run_len   = int'(data[3:0]) + LEN_BIAS;
                    // Reading entry by entry lets a copy repeat bytes it has just written.
                    for (int i = 0; i < run_len; i++)
                        emit_byte(hist_window[copy_from + 12'(i)], i == run_len - 1);
                    parse_phase = (flags_unused != 4'd0) ? PH_ITEM : PH_FLAG;
                end
            end
            default:
            begin
                pending_flags = data;
                flags_unused  = FLAGS_PER_BYTE;
                parse_phase   = PH_ITEM;
            end
        endcase
        if (fin)
            clear_expander();
    endfunction

    // Offers one byte of compressed stream and waits until the block takes it.
    task automatic send_request(input logic [7:0] data, input logic fin);
        int gap;
        gap = (gap_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        expand_request(data, fin);
        requests_sent++;
    endtask

    // Sends the next byte of a stream whose length is fixed in advance; the final one is last.
    task automatic stream_byte(input logic [7:0] data);
        send_request(data, stream_budget == 1);
        stream_budget--;
    endtask

    task automatic note_error(input string what, input int want, input int got);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
        error_count++;
    endtask

    // Output side: compare every accepted byte with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                note_error("unexpected output byte, none", 0, m_tdata);
            end
            else
            begin
                if (m_tdata !== expected_bytes[0].out_byte)
                    note_error("out_byte", expected_bytes[0].out_byte, m_tdata);
                if (m_tlast !== expected_bytes[0].last_in_run)
                    note_error("last_in_run", expected_bytes[0].last_in_run, m_tlast);
                void'(expected_bytes.pop_front());
            end
        end
    end

    // Receiver back-pressure: random stalls while enabled, otherwise always ready.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= idle_length() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without a single request or output byte means the block hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Literals at both extremes, a full-length copy that overlaps its own output, a copy
    // from offset zero, and a flag byte used up to its last flag.
    task automatic test_literals_and_overlapping_copy();
        send_request(8'hF3, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hEE, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h5A, 1'b0);
        send_request(8'hA5, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(8'h80, 1'b1);
    endtask

    // A stream whose only byte is a flag byte produces nothing.
    task automatic test_last_on_flag_byte();
        send_request(8'h55, 1'b1);
    endtask

    // The window must read as zeros again once a stream ends; the first copy wraps past the
    // top of the window. The stream ends on the first byte of a reference.
    task automatic test_window_cleared_after_stream();
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hF0, 1'b0);
        send_request(8'h12, 1'b1);
    endtask

    // A literal, then a reference whose second byte ends the stream, so no copy happens.
    // The next stream reads where that literal was written and must see zeros.
    task automatic test_last_on_reference();
        send_request(8'h01, 1'b0);
        send_request(8'h3C, 1'b0);
        send_request(8'hEE, 1'b0);
        send_request(8'hF5, 1'b1);
        send_request(8'h00, 1'b0);
        send_request(8'hEE, 1'b0);
        send_request(8'hF2, 1'b0);
        send_request(8'h00, 1'b1);
    endtask

    // Mostly well-formed streams cut off at a random byte, with references aimed at recent
    // output so copies carry real data and often overlap; a few streams are pure noise.
    task automatic test_random_streams();
        int          first_request;
        int          k;
        logic [7:0]  flags;
        logic [11:0] copy_from;
        logic [3:0]  len_code;
        first_request = requests_sent;
        while (requests_sent - first_request < RANDOM_REQUESTS)
        begin
            gap_on   = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                stream_budget = $urandom_range(1, 20);
                while (stream_budget > 0)
                    stream_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                stream_budget = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                            : $urandom_range(1, 40);
                while (stream_budget > 0)
                begin
                    flags = 8'($urandom_range(0, 255));
                    stream_byte(flags);
                    for (k = 0; k < 8 && stream_budget > 0; k++)
                    begin
                        if (flags[k])
                        begin
                            stream_byte(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            if ($urandom_range(0, 3) != 0)
                                copy_from = hist_wp - 12'($urandom_range(1, 48));
                            else
                                copy_from = 12'($urandom_range(0, WINDOW_DEPTH_DEF - 1));
                            len_code = 4'($urandom_range(0, 15));
                            stream_byte(copy_from[7:0]);
                            if (stream_budget > 0)
                                stream_byte({copy_from[11:8], len_code});
                        end
                    end
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        error_count   = 0;
        requests_sent = 0;
        stream_budget = 0;
        quiet_cycles  = 0;
        stall_left    = 0;
        gap_on        = 1'b1;
        stall_on      = 1'b1;
        clear_expander();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals_and_overlapping_copy();
        test_last_on_flag_byte();
        test_window_cleared_after_stream();
        test_last_on_reference();
        test_random_streams();

        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
